@@ hw/rtl/sat_pkg.sv @@
`timescale 1ns / 1ps

package sat_pkg;

  // Default table depth
  localparam int MAX_SECTIONS_DEF = 16;

  // Operation codes of an input beat
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_V2F   = 2'd1;
  localparam logic [1:0] OP_F2V   = 2'd2;

  // Outcome codes of a result beat
  localparam logic [1:0] OUT_PASS  = 2'd0;
  localparam logic [1:0] OUT_HIT   = 2'd1;
  localparam logic [1:0] OUT_MISS  = 2'd2;
  localparam logic [1:0] OUT_WRITE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_FILE_ALIGN    = 2'd0;
  localparam logic [1:0] REG_SECTION_ALIGN = 2'd1;
  localparam logic [1:0] REG_HEADER_SIZE   = 2'd2;
  localparam logic [1:0] REG_SECTION_COUNT = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  entry_index;
    logic [31:0] virtual_start;
    logic [31:0] virtual_length;
    logic [31:0] raw_start;
    logic [31:0] raw_length;
    logic [31:0] address;
  } sat_in_t;

  typedef struct packed {
    logic [31:0] translated;
    logic [1:0]  outcome;
  } sat_out_t;

  // One section descriptor as stored in the table
  typedef struct packed {
    logic [31:0] virtual_start;
    logic [31:0] virtual_length;
    logic [31:0] raw_start;
    logic [31:0] raw_length;
  } sat_entry_t;

  // Translation settings seen by the controller
  typedef struct packed {
    logic [31:0] file_alignment;
    logic [31:0] section_alignment;
    logic [31:0] header_size;
  } sat_cfg_t;

endpackage

@@ hw/rtl/sat_table.sv @@
`timescale 1ns / 1ps

module sat_table #(
  parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF,
  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  sat_pkg::sat_entry_t wr_entry,
  input  logic [IDX_W-1:0]    rd_addr,
  output sat_pkg::sat_entry_t rd_entry
);
  import sat_pkg::*;

  sat_entry_t mem [MAX_SECTIONS];

  // Write one descriptor
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_entry <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/sat_ctrl.sv @@
`timescale 1ns / 1ps

module sat_ctrl #(
  parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF,
  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  sat_pkg::sat_cfg_t   cfg,
  input  logic [CNT_W-1:0]    limit,
  input  logic                item_valid,
  output logic                item_stall,
  input  sat_pkg::sat_in_t    item,
  output logic                result_valid,
  input  logic                result_stall,
  output sat_pkg::sat_out_t   result,
  output logic                tbl_wr_en,
  output logic [IDX_W-1:0]    tbl_wr_addr,
  output sat_pkg::sat_entry_t tbl_wr_entry,
  output logic [IDX_W-1:0]    tbl_rd_addr,
  input  sat_pkg::sat_entry_t tbl_rd_entry
);
  import sat_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] chk;
  logic [CNT_W-1:0] chk_inc;
  logic             is_f2v;
  logic [31:0]      addr;
  sat_out_t         pend;

  logic             accept;
  logic             pass;
  logic [31:0]      idx_ext;
  logic             idx_ok;
  logic [31:0]      from_start;
  logic [31:0]      from_len;
  logic [31:0]      to_start;
  logic [32:0]      diff;
  logic             hit;
  logic             out_free;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign chk_inc    = chk + CNT_W'(1);

  // Decode write target and passthrough
  assign idx_ext = 32'(item.entry_index);
  assign idx_ok  = idx_ext < MAX_SECTIONS;
  assign pass    = (cfg.file_alignment == cfg.section_alignment) ||
                   (item.address < cfg.header_size);

  // Table write from an accepted write beat
  assign tbl_wr_en                   = accept && (item.operation == OP_WRITE) && idx_ok;
  assign tbl_wr_addr                 = idx_ext[IDX_W-1:0];
  assign tbl_wr_entry.virtual_start  = item.virtual_start;
  assign tbl_wr_entry.virtual_length = item.virtual_length;
  assign tbl_wr_entry.raw_start      = item.raw_start;
  assign tbl_wr_entry.raw_length     = item.raw_length;

  // Read the entry after the one under test; entry 0 on the accept cycle
  assign tbl_rd_addr = (state == S_SCAN) ? chk_inc[IDX_W-1:0] : '0;

  // Range test of the entry under test
  always_comb begin
    if (is_f2v) begin
      from_start = tbl_rd_entry.raw_start;
      from_len   = tbl_rd_entry.raw_length;
      to_start   = tbl_rd_entry.virtual_start;
    end else begin
      from_start = tbl_rd_entry.virtual_start;
      from_len   = tbl_rd_entry.virtual_length;
      to_start   = tbl_rd_entry.raw_start;
    end
    diff = {1'b0, addr} - {1'b0, from_start};
    hit  = !diff[32] && (diff[31:0] < from_len);
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // Load the pending result, or drop a result once it is taken
      if ((state == S_PUSH) && out_free) begin
        result       <= pend;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            is_f2v <= (item.operation == OP_F2V);
            addr   <= item.address;
            chk    <= '0;
            case (item.operation) inside
              OP_WRITE: begin
                pend  <= '{translated: 32'd0, outcome: OUT_WRITE};
                state <= S_PUSH;
              end
              OP_V2F, OP_F2V: begin
                if (pass) begin
                  pend  <= '{translated: item.address, outcome: OUT_PASS};
                  state <= S_PUSH;
                end else if (limit == '0) begin
                  pend  <= '{translated: 32'd0, outcome: OUT_MISS};
                  state <= S_PUSH;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                pend  <= '{translated: 32'd0, outcome: OUT_MISS};
                state <= S_PUSH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            pend  <= '{translated: diff[31:0] + to_start, outcome: OUT_HIT};
            state <= S_PUSH;
          end else if (chk_inc == limit) begin
            pend  <= '{translated: 32'd0, outcome: OUT_MISS};
            state <= S_PUSH;
          end else begin
            chk <= chk_inc;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_wr_only_idle: assert property (@(posedge clk) disable iff (rst)
    tbl_wr_en |-> (state == S_IDLE) && item_valid && (item.operation == OP_WRITE))
    else $error("table write outside an accepted write beat");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) && (pend.outcome == OUT_WRITE) |-> (pend.translated == 32'd0))
    else $error("write result carries a nonzero address");

  a_load_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_PUSH))
    else $error("result loaded outside the push step");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (state == S_SCAN) || (state == S_PUSH))
    else $error("scan left without a result");
`endif

endmodule

@@ hw/rtl/section_address_translator_core.sv @@
`timescale 1ns / 1ps

// Section address translator: a table of up to MAX_SECTIONS section
// descriptors in a synchronous memory, loaded by write beats and searched
// by translate beats (virtual to file or file to virtual). One item is in
// work at a time. A write, a passthrough, an unused operation or a search
// with a section count of zero skips the scan. A search tests one table
// entry per cycle through the memory's single read port, at most
// min(section_count, MAX_SECTIONS) entries; the first hit ends it early.
// A new beat is taken once the previous result sits in the result
// register, even while that result is still stalled. The table is not
// cleared at reset; the user must see that entries are read only after
// they were written, and the block itself does not enforce this.
// Configuration writes are always ready and take effect at once.
module section_address_translator_core #(
  parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  sat_pkg::sat_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output sat_pkg::sat_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import sat_pkg::*;

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

  sat_cfg_t         cfg;
  logic [4:0]       section_count;
  logic [31:0]      cnt_ext;
  logic [CNT_W-1:0] limit;

  logic             tbl_wr_en;
  logic [IDX_W-1:0] tbl_wr_addr;
  sat_entry_t       tbl_wr_entry;
  logic [IDX_W-1:0] tbl_rd_addr;
  sat_entry_t       tbl_rd_entry;

  assign cfg_ready = 1'b1;

  // Load configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.file_alignment    <= 32'd512;
      cfg.section_alignment <= 32'd4096;
      cfg.header_size       <= 32'd1024;
      section_count         <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FILE_ALIGN:    cfg.file_alignment    <= cfg_data;
        REG_SECTION_ALIGN: cfg.section_alignment <= cfg_data;
        REG_HEADER_SIZE:   cfg.header_size       <= cfg_data;
        REG_SECTION_COUNT: section_count         <= cfg_data[4:0];
      endcase
    end
  end

  // Clamp the search length to the table depth
  assign cnt_ext = 32'(section_count);
  assign limit   = (cnt_ext > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS) : CNT_W'(cnt_ext);

  sat_ctrl #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .limit        (limit),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .tbl_wr_en    (tbl_wr_en),
    .tbl_wr_addr  (tbl_wr_addr),
    .tbl_wr_entry (tbl_wr_entry),
    .tbl_rd_addr  (tbl_rd_addr),
    .tbl_rd_entry (tbl_rd_entry)
  );

  sat_table #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_table (
    .clk      (clk),
    .wr_en    (tbl_wr_en),
    .wr_addr  (tbl_wr_addr),
    .wr_entry (tbl_wr_entry),
    .rd_addr  (tbl_rd_addr),
    .rd_entry (tbl_rd_entry)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import sat_pkg::*;

  localparam int TABLE_DEPTH = MAX_SECTIONS_DEF;
  localparam int PHASE_COUNT = 9;
  localparam int PHASE_BEATS = 148;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 4000;
  // The package names no code for the fourth operation.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic {ROW_BEAT, ROW_SETTINGS} row_kind_e;

  typedef struct packed {
    logic [31:0] file_align;
    logic [31:0] sect_align;
    logic [31:0] hdr_size;
    logic [31:0] sec_count;
  } settings_t;

  typedef struct {
    row_kind_e kind;
    sat_in_t   beat;
    logic      typed;
    sat_out_t  want;
    settings_t setting;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  sat_in_t     in_beat;
  logic        result_valid;
  logic        result_stall;
  sat_out_t    out_beat;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // Shadow copy of the section table and the settings
  sat_entry_t             sect_tbl [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_written;
  logic [31:0]            file_align_q;
  logic [31:0]            sect_align_q;
  logic [31:0]            hdr_size_q;
  logic [4:0]             sec_count_q;

  sat_out_t pending_results [$];
  int       failures = 0;
  bit       no_idle;
  bit       hold_request;
  int       idle_cycles = 0;

  section_address_translator_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (in_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (out_beat),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Work out the translation of one beat and update the shadow table
  function automatic sat_out_t predict_translation(input sat_in_t x);
    sat_out_t    r;
    int unsigned span;
    logic [31:0] from_s;
    logic [31:0] from_l;
    logic [31:0] to_s;
    bit          hit;
    r.translated = '0;
    r.outcome = OUT_MISS;
    hit = 1'b0;
    if (x.operation == OP_WRITE) begin
      if (x.entry_index < TABLE_DEPTH) begin
        sect_tbl[x.entry_index] = '{x.virtual_start, x.virtual_length,
                                    x.raw_start, x.raw_length};
        entry_written[x.entry_index] = 1'b1;
      end
      r.outcome = OUT_WRITE;
    end else if (x.operation == OP_V2F || x.operation == OP_F2V) begin
      if (file_align_q == sect_align_q || x.address < hdr_size_q) begin
        r.translated = x.address;
        r.outcome = OUT_PASS;
      end else begin
        span = (sec_count_q > TABLE_DEPTH) ? TABLE_DEPTH : sec_count_q;
        // first section holding the address wins; the end test is 33 bits wide
        for (int i = 0; i < span && !hit; i++) begin
          if (x.operation == OP_V2F) begin
            from_s = sect_tbl[i].virtual_start;
            from_l = sect_tbl[i].virtual_length;
            to_s = sect_tbl[i].raw_start;
          end else begin
            from_s = sect_tbl[i].raw_start;
            from_l = sect_tbl[i].raw_length;
            to_s = sect_tbl[i].virtual_start;
          end
          if (x.address >= from_s &&
              {1'b0, x.address} < {1'b0, from_s} + {1'b0, from_l}) begin
            r.translated = x.address - from_s + to_s;
            r.outcome = OUT_HIT;
            hit = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_start();
    return ($urandom_range(3) == 0) ? $urandom : ($urandom & 32'h00FF_F000);
  endfunction

  // Mostly small sections, some empty, some running up to or past the top
  function automatic logic [31:0] pick_length(input logic [31:0] start);
    case ($urandom_range(9))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'd0 - start + $urandom_range(0, 32'h800);
      default: return $urandom_range(1, 32'h8000);
    endcase
  endfunction

  function automatic sat_in_t section_write(input logic [3:0] idx);
    sat_in_t b;
    b.operation = OP_WRITE;
    b.entry_index = idx;
    b.virtual_start = pick_start();
    b.virtual_length = pick_length(b.virtual_start);
    b.raw_start = pick_start();
    b.raw_length = pick_length(b.raw_start);
    b.address = $urandom;
    return b;
  endfunction

  // Random beat: mostly lookups aimed at live sections, plus writes and noise
  function automatic sat_in_t random_beat();
    sat_in_t     b;
    sat_entry_t  e;
    logic [31:0] fs;
    logic [31:0] fl;
    int unsigned span;
    int unsigned pick;
    span = (sec_count_q > TABLE_DEPTH) ? TABLE_DEPTH : sec_count_q;
    pick = $urandom_range(99);
    if (pick < 12) return section_write(4'($urandom_range(TABLE_DEPTH - 1)));
    b.operation = OP_UNUSED;
    b.entry_index = 4'($urandom_range(15));
    b.virtual_start = $urandom;
    b.virtual_length = $urandom;
    b.raw_start = $urandom;
    b.raw_length = $urandom;
    b.address = $urandom;
    if (pick < 16) return b;
    b.operation = $urandom_range(1) ? OP_V2F : OP_F2V;
    if (pick < 80 && span > 0) begin
      e = sect_tbl[$urandom_range(span - 1)];
      fs = (b.operation == OP_V2F) ? e.virtual_start : e.raw_start;
      fl = (b.operation == OP_V2F) ? e.virtual_length : e.raw_length;
      case ($urandom_range(9))
        0: b.address = fs;
        1: b.address = fs + fl - 32'd1;
        2: b.address = fs + fl;
        3: b.address = fs - 32'd1;
        default: b.address = (fl == 0) ? fs : fs + $urandom_range(fl - 32'd1);
      endcase
    end else if (pick >= 95) begin
      case ($urandom_range(3))
        0: b.address = 32'hFFFF_FFFF;
        1: b.address = hdr_size_q;
        2: b.address = hdr_size_q - 32'd1;
        default: b.address = 32'd0;
      endcase
    end
    return b;
  endfunction

  function automatic stim_row_t beat_row(input logic [1:0] op, input logic [3:0] idx,
                                         input logic [31:0] vs, input logic [31:0] vl,
                                         input logic [31:0] rs, input logic [31:0] rl,
                                         input logic [31:0] addr);
    stim_row_t row;
    row.kind = ROW_BEAT;
    row.beat = '{op, idx, vs, vl, rs, rl, addr};
    row.typed = 1'b0;
    row.want = '0;
    row.setting = '0;
    return row;
  endfunction

  function automatic stim_row_t known(input stim_row_t row, input logic [31:0] t,
                                      input logic [1:0] o);
    row.typed = 1'b1;
    row.want = '{t, o};
    return row;
  endfunction

  function automatic stim_row_t settings_row(input logic [31:0] fa, input logic [31:0] sa,
                                             input logic [31:0] hs, input logic [31:0] cnt);
    stim_row_t row;
    row.kind = ROW_SETTINGS;
    row.beat = '0;
    row.typed = 1'b0;
    row.want = '0;
    row.setting = '{fa, sa, hs, cnt};
    return row;
  endfunction

  // Offer one beat, hold it until taken, then queue its expected result
  task automatic send_item(input sat_in_t x, input logic typed, input sat_out_t want);
    sat_out_t predicted;
    while (!no_idle && $urandom_range(99) < 36) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    in_beat <= x;
    do @(posedge clk); while (item_stall);
    predicted = predict_translation(x);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain_results(input int settle);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [1:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four registers in one burst
  task automatic load_config(input settings_t s);
    cfg_valid <= 1'b1;
    cfg_beat(REG_FILE_ALIGN, s.file_align);
    cfg_beat(REG_SECTION_ALIGN, s.sect_align);
    cfg_beat(REG_HEADER_SIZE, s.hdr_size);
    cfg_beat(REG_SECTION_COUNT, s.sec_count);
    cfg_valid <= 1'b0;
    file_align_q = s.file_align;
    sect_align_q = s.sect_align;
    hdr_size_q = s.hdr_size;
    sec_count_q = s.sec_count[4:0];
  endtask

  // Result side: check each beat, stall at random, hold off once on request
  initial begin : result_sink
    int       hold_left;
    bit       hold_done;
    sat_out_t want;
    hold_left = 0;
    hold_done = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: translated %h outcome %0d",
                 out_beat.translated, out_beat.outcome);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (out_beat.translated !== want.translated) begin
            $error("translated: expected %h, got %h", want.translated, out_beat.translated);
            failures++;
          end
          if (out_beat.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, out_beat.outcome);
            failures++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !no_idle && ($urandom_range(99) < 36);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed [$];
    settings_t phase_plan [PHASE_COUNT];
    no_idle = 1'b0;
    hold_request = 1'b0;
    entry_written = '0;
    foreach (sect_tbl[i]) sect_tbl[i] = '0;
    file_align_q = 32'd512;
    sect_align_q = 32'd4096;
    hdr_size_q = 32'd1024;
    sec_count_q = 5'd0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    in_beat <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FILE_ALIGN;
    cfg_data <= '0;

    // Settings after reset, then four sections, two of them overlapping, and a full one
    directed.push_back(known(beat_row(OP_V2F, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                      32'h0), 32'h0, OUT_PASS));
    directed.push_back(known(beat_row(OP_F2V, 4'hF, '1, '1, '1, '1,
                                      32'h3FF), 32'h3FF, OUT_PASS));
    directed.push_back(known(beat_row(OP_V2F, 4'h5, 32'h1000, 32'h1000, 32'h0, 32'h1000,
                                      32'hFFFF_FFFF), 32'h0, OUT_MISS));
    directed.push_back(known(beat_row(OP_UNUSED, 4'hA, '1, '1, '1, '1,
                                      32'h2000), 32'h0, OUT_MISS));
    directed.push_back(known(beat_row(OP_WRITE, 4'h0, 32'h1000, 32'h2000, 32'h400, 32'h1800,
                                      32'hFFFF_FFFF), 32'h0, OUT_WRITE));
    // empty section in both directions
    directed.push_back(known(beat_row(OP_WRITE, 4'h1, 32'h3000, 32'h0, 32'h2000, 32'h0,
                                      32'h0), 32'h0, OUT_WRITE));
    // ends exactly at the top, and raw range running past it
    directed.push_back(known(beat_row(OP_WRITE, 4'h2, 32'hFFFF_F000, 32'h1000,
                                      32'hFFFF_FF00, 32'h200, 32'h0), 32'h0, OUT_WRITE));
    // overlaps entry 0, which must win where both hold
    directed.push_back(known(beat_row(OP_WRITE, 4'h3, 32'h1000, 32'h4000, 32'h7000, 32'h800,
                                      32'h0), 32'h0, OUT_WRITE));
    directed.push_back(settings_row(32'd512, 32'd4096, 32'd1024, 32'd4));
    directed.push_back(beat_row(OP_V2F, 4'h0, '0, '0, '0, '0, 32'h1000));
    directed.push_back(beat_row(OP_V2F, 4'h0, '0, '0, '0, '0, 32'h2FFF));
    directed.push_back(beat_row(OP_V2F, 4'h0, '0, '0, '0, '0, 32'h3000));
    // sum past the top wraps
    directed.push_back(beat_row(OP_V2F, 4'h0, '0, '0, '0, '0, 32'hFFFF_FFFF));
    directed.push_back(beat_row(OP_F2V, 4'h0, '0, '0, '0, '0, 32'hFFFF_FFFF));
    directed.push_back(known(beat_row(OP_F2V, 4'h3, '1, '1, '1, '1,
                                      32'h3FF), 32'h3FF, OUT_PASS));
    directed.push_back(known(beat_row(OP_F2V, 4'h3, '1, '1, '1, '1,
                                      32'h5000), 32'h0, OUT_MISS));
    directed.push_back(known(beat_row(OP_WRITE, 4'hF, '1, '1, '1, '1, '1),
                             32'h0, OUT_WRITE));
    // equal alignments pass everything through
    directed.push_back(settings_row(32'h200, 32'h200, 32'hFFFF_FFFF, 32'd4));
    directed.push_back(known(beat_row(OP_V2F, 4'h0, '0, '0, '0, '0, 32'hFFFF_FFFF),
                             32'hFFFF_FFFF, OUT_PASS));
    directed.push_back(settings_row(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0));
    directed.push_back(known(beat_row(OP_F2V, 4'h0, '0, '0, '0, '0, 32'h0),
                             32'h0, OUT_MISS));

    phase_plan = '{
      '{32'd512,       32'd4096,      32'd1024,      32'd4},
      '{32'd512,       32'd4096,      32'd0,         32'd16},
      '{32'd0,         32'hFFFF_FFFF, 32'h400,       32'd31},
      '{32'h1000,      32'h1000,      32'h2000,      32'd8},
      '{32'hFFFF_FFFF, 32'd0,         32'hFFFF_FFFF, 32'd16},
      '{32'd512,       32'd4096,      32'd1024,      32'd0},
      '{32'h200,       32'h1000,      32'h100,       32'd1},
      '{32'd512,       32'd4096,      32'h400,       32'hFFFF_FFFF},
      '{32'd512,       32'd4096,      32'd1024,      32'd16}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (directed[r]) begin
      if (directed[r].kind == ROW_SETTINGS) begin
        drain_results(4);
        load_config(directed[r].setting);
      end else begin
        send_item(directed[r].beat, directed[r].typed, directed[r].want);
      end
    end

    // Load every entry not yet written so any count reads defined data
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!entry_written[i]) send_item(section_write(4'(i)), 1'b0, '0);
    end

    // Random phases, one setting each
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results(4);
      load_config(phase_plan[p]);
      no_idle = (p == 2);
      if (p == PHASE_COUNT - 1) hold_request = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (p == 1 && n == PHASE_BEATS / 2) drain_results(2);
        send_item(random_beat(), 1'b0, '0);
      end
    end

    drain_results(SETTLE_CYCLES);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
